@@ hdl/sicd_pkg.sv @@
`default_nettype none
package sicd_pkg;

    localparam int STORE_BYTES  = 2048;
    localparam int STORE_ADDR_W = $clog2(STORE_BYTES);
    localparam int PTR_W        = 13;

    localparam logic       KIND_READ  = 1'b0;
    localparam logic       KIND_WRITE = 1'b1;

    localparam logic [3:0] PORT_ID      = 4'h0;
    localparam logic [3:0] PORT_SWITCH  = 4'h1;
    localparam logic [3:0] PORT_COLOUR  = 4'h3;
    localparam logic [3:0] PORT_PATTERN = 4'h4;
    localparam logic [3:0] PORT_PTR_LO  = 4'h7;
    localparam logic [3:0] PORT_PTR_HI  = 4'h8;
    localparam logic [3:0] PORT_DATA    = 4'h9;

    localparam logic [7:0] ID_BYTE    = 8'hf7;
    localparam logic [7:0] IDLE_BYTE  = 8'hff;
    localparam logic [7:0] ERASE_BYTE = 8'hff;

    typedef struct packed {
        logic       kind;
        logic [3:0] port;
        logic [7:0] wdata;
        logic       front_switch_on;
    } sicd_in_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       turbo_on;
    } sicd_out_t;

    // One accepted request as seen by the store and the result stage
    typedef struct packed {
        logic                    ram_rd;
        logic                    ram_wr;
        logic [STORE_ADDR_W-1:0] addr;
        logic [7:0]              wdata;
        logic                    from_ram;
        logic [7:0]              rdata;
        logic                    turbo_on;
    } sicd_access_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } sicd_state_t;

endpackage
`default_nettype wire

@@ hdl/sicd_ram.sv @@
`default_nettype none
module sicd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/sicd_regfile.sv @@
`default_nettype none
module sicd_regfile
    import sicd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     acc,
    input  wire sicd_in_t item,
    input  wire logic     cfg_we,
    input  wire logic     cfg_data,
    output sicd_access_t access
);

    logic [PTR_W-1:0] ptr_reg,     ptr_next;
    logic [3:0]       col_lo_reg,  col_lo_next;
    logic [3:0]       col_hi_reg,  col_hi_next;
    logic [7:0]       pat_reg,     pat_next;
    logic             turbo_reg,   turbo_next;
    logic             fitted_reg,  fitted_next;
    logic             in_range;
    logic [3:0]       nib_hi;
    logic [3:0]       nib_lo;
    logic [7:0]       sw_byte;

    always_comb
    begin
        in_range = {1'b0, ptr_reg} < (PTR_W + 1)'(STORE_BYTES);
        nib_hi   = pat_reg[7] ? col_hi_reg : col_lo_reg;
        nib_lo   = pat_reg[6] ? col_hi_reg : col_lo_reg;

        sw_byte = IDLE_BYTE;
        if (item.front_switch_on)
        begin
            sw_byte[7] = 1'b0;
        end
        if (fitted_reg)
        begin
            sw_byte[2] = 1'b0;
            if (turbo_reg)
            begin
                sw_byte[0] = 1'b0;
            end
        end

        ptr_next    = ptr_reg;
        col_lo_next = col_lo_reg;
        col_hi_next = col_hi_reg;
        pat_next    = pat_reg;
        turbo_next  = turbo_reg;
        fitted_next = fitted_reg;

        access          = '0;
        access.addr     = ptr_reg[STORE_ADDR_W-1:0];
        access.wdata    = item.wdata;
        access.rdata    = IDLE_BYTE;

        if (item.kind == KIND_WRITE)
        begin
            case (item.port)
                PORT_SWITCH:
                begin
                    if (fitted_reg)
                    begin
                        turbo_next = ~item.wdata[0];
                    end
                end
                PORT_COLOUR:
                begin
                    col_hi_next = item.wdata[7:4];
                    col_lo_next = item.wdata[3:0];
                end
                PORT_PATTERN: pat_next = item.wdata;
                PORT_PTR_LO:  ptr_next = {ptr_reg[PTR_W-1:8], item.wdata};
                PORT_PTR_HI:  ptr_next = {item.wdata[4:0], ptr_reg[7:0]};
                PORT_DATA:
                begin
                    access.ram_wr = acc && in_range;
                    ptr_next      = ptr_reg + 1'b1;
                end
                default: ;
            endcase
        end
        else
        begin
            case (item.port)
                PORT_ID:     access.rdata = ID_BYTE;
                PORT_SWITCH: access.rdata = sw_byte;
                PORT_COLOUR:
                begin
                    access.rdata = {nib_hi, nib_lo};
                    pat_next     = {pat_reg[5:0], pat_reg[7:6]};
                end
                PORT_DATA:
                begin
                    access.ram_rd   = acc && in_range;
                    access.from_ram = in_range;
                    ptr_next        = ptr_reg + 1'b1;
                end
                default: ;
            endcase
        end

        access.turbo_on = turbo_next;

        if (!acc)
        begin
            ptr_next    = ptr_reg;
            col_lo_next = col_lo_reg;
            col_hi_next = col_hi_reg;
            pat_next    = pat_reg;
            turbo_next  = turbo_reg;
        end

        // Removing the option drops turbo back to normal speed
        if (cfg_we)
        begin
            fitted_next = cfg_data;
            if (!cfg_data)
            begin
                turbo_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            col_lo_reg <= '0;
            col_hi_reg <= '0;
            pat_reg    <= '0;
            turbo_reg  <= 1'b0;
            fitted_reg <= 1'b0;
        end
        else
        begin
            ptr_reg    <= ptr_next;
            col_lo_reg <= col_lo_next;
            col_hi_reg <= col_hi_next;
            pat_reg    <= pat_next;
            turbo_reg  <= turbo_next;
            fitted_reg <= fitted_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/switched_io_sram_color_device_core.sv @@
`default_nettype none
// Path: an accepted request goes into the result stage register, then into rsp_reg.
// Throughput: one request per cycle while req_stall is low; each request uses the
// store's read or write port at most once, and store read data is registered.
// Reset: rst_n clears all control state, then a clearing pass writes 0xFF to every
// store byte, one per cycle, with req_stall held high until the pass is done.
module switched_io_sram_color_device_core
    import sicd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire sicd_in_t  req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output sicd_out_t      rsp,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_data
);

    sicd_state_t             state_reg, state_next;
    logic [STORE_ADDR_W-1:0] clr_reg,   clr_next;
    logic                    s1_valid_reg, s1_valid_next;
    logic                    s1_ram_reg;
    logic [7:0]              s1_rdata_reg;
    logic                    s1_turbo_reg;
    logic                    rsp_valid_reg, rsp_valid_next;
    sicd_out_t               rsp_reg;
    logic                    s1_move;
    logic                    acc;
    sicd_access_t            access;
    logic                    ram_we;
    logic [STORE_ADDR_W-1:0] ram_waddr;
    logic [7:0]              ram_wdata;
    logic [7:0]              ram_rdata;

    assign cfg_ready = 1'b1;
    assign s1_move   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = (state_reg != ST_RUN) || (s1_valid_reg && !s1_move);
    assign acc       = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    sicd_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc),
        .item     (req),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .access   (access)
    );

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = ERASE_BYTE;
        end
        else
        begin
            ram_we    = access.ram_wr;
            ram_waddr = access.addr;
            ram_wdata = access.wdata;
        end
    end

    sicd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (access.ram_rd),
        .raddr (access.addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == STORE_ADDR_W'(STORE_BYTES - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: ;
            default: state_next = ST_CLEAR;
        endcase

        s1_valid_next = acc || (s1_valid_reg && !s1_move);

        // Advance the result stage, or drop the response once taken
        if (s1_move)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_ram_reg   <= access.from_ram;
            s1_rdata_reg <= access.rdata;
            s1_turbo_reg <= access.turbo_on;
        end
        if (s1_move)
        begin
            rsp_reg.rdata    <= s1_ram_reg ? ram_rdata : s1_rdata_reg;
            rsp_reg.turbo_on <= s1_turbo_reg;
        end
    end

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
module tb_top
    import sicd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 2;
    localparam int STALL_LIMIT = STORE_BYTES + 5000;
    localparam int PHASE_ITEMS = 100;
    localparam logic [3:0] MAPPED_PORTS [7] = '{PORT_ID, PORT_SWITCH, PORT_COLOUR,
        PORT_PATTERN, PORT_PTR_LO, PORT_PTR_HI, PORT_DATA};

    // Predicts the device's response to each request and holds them until they arrive
    class sicd_scoreboard;
        logic [7:0]       sram [STORE_BYTES];
        logic [PTR_W-1:0] ptr;
        logic [3:0]       colour_lo;
        logic [3:0]       colour_hi;
        logic [7:0]       pattern;
        logic             turbo;
        logic             turbo_fitted;
        sicd_out_t        pending_rsp [$];
        int               errors;

        function new();
            foreach (sram[i])
                sram[i] = ERASE_BYTE;
            ptr          = '0;
            colour_lo    = '0;
            colour_hi    = '0;
            pattern      = '0;
            turbo        = 1'b0;
            turbo_fitted = 1'b0;
            errors       = 0;
        endfunction

        function void set_fitted(logic v);
            turbo_fitted = v;
            // removing the option drops turbo
            if (!v)
                turbo = 1'b0;
        endfunction

        function void note_request(sicd_in_t r);
            sicd_out_t  e;
            logic [3:0] hi_n;
            logic [3:0] lo_n;
            e.rdata = IDLE_BYTE;
            if (r.kind == KIND_WRITE)
            begin
                case (r.port)
                    PORT_SWITCH:  if (turbo_fitted) turbo = ~r.wdata[0];
                    PORT_COLOUR:
                    begin
                        colour_hi = r.wdata[7:4];
                        colour_lo = r.wdata[3:0];
                    end
                    PORT_PATTERN: pattern = r.wdata;
                    PORT_PTR_LO:  ptr[7:0] = r.wdata;
                    PORT_PTR_HI:  ptr[12:8] = r.wdata[4:0];
                    PORT_DATA:
                    begin
                        if (ptr < STORE_BYTES)
                            sram[ptr[STORE_ADDR_W-1:0]] = r.wdata;
                        ptr = ptr + 1'b1;
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (r.port)
                    PORT_ID: e.rdata = ID_BYTE;
                    PORT_SWITCH:
                    begin
                        if (r.front_switch_on)
                            e.rdata[7] = 1'b0;
                        if (turbo_fitted)
                        begin
                            e.rdata[2] = 1'b0;
                            if (turbo)
                                e.rdata[0] = 1'b0;
                        end
                    end
                    PORT_COLOUR:
                    begin
                        hi_n    = pattern[7] ? colour_hi : colour_lo;
                        lo_n    = pattern[6] ? colour_hi : colour_lo;
                        e.rdata = {hi_n, lo_n};
                        pattern = {pattern[5:0], pattern[7:6]};
                    end
                    PORT_DATA:
                    begin
                        if (ptr < STORE_BYTES)
                            e.rdata = sram[ptr[STORE_ADDR_W-1:0]];
                        ptr = ptr + 1'b1;
                    end
                    default: ;
                endcase
            end
            e.turbo_on = turbo;
            pending_rsp.push_back(e);
        endfunction

        function void check_response(sicd_out_t got);
            sicd_out_t e;
            if (pending_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: response with none outstanding: rdata %02h turbo_on %0b",
                         $realtime, got.rdata, got.turbo_on);
                return;
            end
            e = pending_rsp.pop_front();
            if (got.rdata !== e.rdata)
            begin
                errors++;
                $display("%0t: rdata expected %02h got %02h", $realtime, e.rdata, got.rdata);
            end
            if (got.turbo_on !== e.turbo_on)
            begin
                errors++;
                $display("%0t: turbo_on expected %0b got %0b", $realtime, e.turbo_on,
                         got.turbo_on);
            end
        endfunction

        function int outstanding();
            return pending_rsp.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    sicd_in_t  req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    sicd_out_t rsp;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;

    sicd_scoreboard sb = new();

    int  sent        = 0;
    int  idle_cycles = 0;
    int  stall_left  = 0;
    bit  req_steady  = 1'b0;
    bit  rsp_steady  = 1'b0;

    switched_io_sram_color_device_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // mostly short, now and then long
    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Response side: check accepted responses, stall at random
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (!rsp_steady && $urandom_range(0, 3) == 0)
                stall_left = idle_length();
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic issue(logic kind, logic [3:0] port, logic [7:0] wdata, logic front);
        sicd_in_t    r;
        int unsigned gap;
        r.kind            = kind;
        r.port            = port;
        r.wdata           = wdata;
        r.front_switch_on = front;
        gap = req_steady ? 0 : idle_length();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
        sb.note_request(r);
        sent++;
    endtask

    // Hold off until every response is back
    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
    endtask

    task automatic write_fitted(logic v);
        wait_drained();
        repeat (LATENCY + 2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_fitted(v);
    endtask

    task automatic set_pointer(logic [PTR_W-1:0] addr);
        logic [2:0] junk;
        junk = 3'($urandom_range(0, 7));
        issue(KIND_WRITE, PORT_PTR_LO, addr[7:0], rand_bit());
        issue(KIND_WRITE, PORT_PTR_HI, {junk, addr[12:8]}, rand_bit());
    endtask

    // Write a run of bytes, rewind and read them back
    task automatic store_burst();
        logic [PTR_W-1:0] base;
        int unsigned      len;
        if ($urandom_range(0, 7) == 0)
            base = PTR_W'($urandom_range(STORE_BYTES - 8, 8191));
        else
            base = PTR_W'($urandom_range(0, STORE_BYTES - 1));
        len = $urandom_range(1, 12);
        set_pointer(base);
        repeat (len)
            issue(KIND_WRITE, PORT_DATA, rand_byte(), rand_bit());
        set_pointer(base);
        repeat (len)
            issue(KIND_READ, PORT_DATA, rand_byte(), rand_bit());
    endtask

    task automatic pattern_run();
        issue(KIND_WRITE, PORT_COLOUR, rand_byte(), rand_bit());
        issue(KIND_WRITE, PORT_PATTERN, rand_byte(), rand_bit());
        repeat ($urandom_range(1, 6))
            issue(KIND_READ, PORT_COLOUR, rand_byte(), rand_bit());
    endtask

    task automatic random_access();
        logic       kind;
        logic [3:0] port;
        logic [7:0] wdata;
        kind  = rand_bit();
        wdata = rand_byte();
        if ($urandom_range(0, 9) < 7)
            port = MAPPED_PORTS[$urandom_range(0, 6)];
        else
            port = 4'($urandom_range(0, 15));
        // keep the pointer inside the store most of the time
        if (kind == KIND_WRITE && port == PORT_PTR_HI && $urandom_range(0, 3) != 0)
            wdata[4:3] = 2'b00;
        issue(kind, port, wdata, rand_bit());
    endtask

    initial
    begin
        int          phase_start;
        int unsigned pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // option absent: identity, switch, colours, pointer edges, unmapped ports
        issue(KIND_READ,  PORT_ID,      8'h00, 1'b0);
        issue(KIND_READ,  PORT_SWITCH,  8'hff, 1'b0);
        issue(KIND_READ,  PORT_SWITCH,  8'h00, 1'b1);
        issue(KIND_WRITE, PORT_SWITCH,  8'h00, 1'b0);
        issue(KIND_READ,  PORT_SWITCH,  8'h00, 1'b0);
        issue(KIND_WRITE, PORT_COLOUR,  8'ha5, 1'b1);
        issue(KIND_WRITE, PORT_PATTERN, 8'hc6, 1'b0);
        repeat (4)
            issue(KIND_READ, PORT_COLOUR, 8'h00, 1'b0);
        issue(KIND_WRITE, PORT_PTR_LO,  8'hff, 1'b0);
        issue(KIND_WRITE, PORT_PTR_HI,  8'hff, 1'b1);
        issue(KIND_WRITE, PORT_DATA,    8'h12, 1'b0);
        issue(KIND_WRITE, PORT_DATA,    8'h00, 1'b0);
        issue(KIND_WRITE, PORT_PTR_LO,  8'h00, 1'b0);
        issue(KIND_READ,  PORT_DATA,    8'h00, 1'b1);
        issue(KIND_READ,  PORT_DATA,    8'h00, 1'b0);
        issue(KIND_WRITE, PORT_PTR_LO,  8'hff, 1'b0);
        issue(KIND_WRITE, PORT_PTR_HI,  8'h07, 1'b0);
        issue(KIND_WRITE, PORT_DATA,    8'h5a, 1'b0);
        issue(KIND_WRITE, PORT_PTR_LO,  8'hff, 1'b0);
        issue(KIND_READ,  PORT_DATA,    8'h00, 1'b0);
        issue(KIND_READ,  PORT_DATA,    8'h00, 1'b0);
        issue(KIND_READ,  4'hf,         8'h00, 1'b1);
        issue(KIND_WRITE, 4'hf,         8'hff, 1'b1);
        issue(KIND_WRITE, 4'h2,         8'h3c, 1'b0);

        // option fitted: turbo on and off, then remove it while on
        write_fitted(1'b1);
        issue(KIND_READ,  PORT_SWITCH, 8'h00, 1'b0);
        issue(KIND_WRITE, PORT_SWITCH, 8'h00, 1'b0);
        issue(KIND_READ,  PORT_SWITCH, 8'h00, 1'b1);
        issue(KIND_WRITE, PORT_SWITCH, 8'h01, 1'b0);
        issue(KIND_READ,  PORT_SWITCH, 8'h00, 1'b0);
        issue(KIND_WRITE, PORT_SWITCH, 8'hfe, 1'b0);
        write_fitted(1'b0);
        issue(KIND_READ,  PORT_SWITCH, 8'h00, 1'b0);

        for (int ph = 0; ph < 4; ph++)
        begin
            req_steady = ($urandom_range(0, 3) == 0);
            rsp_steady = ($urandom_range(0, 3) == 0);
            write_fitted((ph % 2) == 0);
            phase_start = sent;
            while (sent - phase_start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    store_burst();
                else if (pick < 42)
                    pattern_run();
                else if (pick < 44)
                    wait_drained();
                else
                    random_access();
            end
        end

        wait_drained();
        repeat (LATENCY + 6) @(posedge clk);
        if (sb.outstanding() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d responses never arrived", $realtime, sb.outstanding());
        end
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ switched_io_sram_color_device_core.f @@
hdl/sicd_pkg.sv
hdl/sicd_ram.sv
hdl/sicd_regfile.sv
hdl/switched_io_sram_color_device_core.sv
sim/tb_top.sv
